/* rtl/skf_pkg.sv */
// Shared constants and types of the scalar Kalman filter.
// No dependencies; every other file of the block except skf_if imports this package.
package skf_pkg;

	localparam int SAMPLE_WIDTH_DEF   = 16;
	localparam int GAIN_FRAC_BITS_DEF = 16;

	localparam int EST_W    = 24;
	localparam int EST_FRAC = 8;
	localparam int COV_W    = 24;
	localparam int CFG_W    = 24;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam int EST_MAX = 8388607;
	localparam int EST_MIN = -8388608;

	localparam logic [CFG_W-1:0] PN_RESET = CFG_W'(655);
	localparam logic [CFG_W-1:0] MN_RESET = CFG_W'(65536);

	localparam int REG_IDX_W = 1;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_PROCESS_NOISE     = 1'b0;
	localparam reg_idx_t REG_MEASUREMENT_NOISE = 1'b1;

	typedef struct packed {
		logic [CFG_W-1:0] process_noise;
		logic [CFG_W-1:0] measurement_noise;
	} cfg_t;

endpackage

/* rtl/skf_if.sv */
// Valid/ready channel interfaces for measurement and result items.
// No dependencies; the sample and gain widths are set by the instantiating environment.
interface skf_sample_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] measurement;

	modport source (output valid, output measurement, input ready);
	modport sink (input valid, input measurement, output ready);
endinterface

interface skf_result_if #(
	parameter int GAIN_FRAC_BITS = 16
);
	logic                      valid;
	logic                      ready;
	logic signed [23:0]        filtered_estimate;
	logic [GAIN_FRAC_BITS:0]   kalman_gain;

	modport source (output valid, output filtered_estimate, output kalman_gain, input ready);
	modport sink (input valid, input filtered_estimate, input kalman_gain, output ready);
endinterface

/* rtl/skf_cfg.sv */
// APB register file holding the process and measurement noise settings.
// Depends on skf_pkg.
module skf_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [skf_pkg::APB_AW-1:0] paddr,
	input  logic [skf_pkg::APB_DW-1:0] pwdata,
	output logic [skf_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output skf_pkg::cfg_t              cfg
);
	import skf_pkg::*;

	logic [CFG_W-1:0] pn_q;
	logic [CFG_W-1:0] mn_q;
	reg_idx_t         idx;
	logic             wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[APB_AW-1:2];
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pn_q <= PN_RESET;
			mn_q <= MN_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_PROCESS_NOISE:     pn_q <= pwdata[CFG_W-1:0];
				REG_MEASUREMENT_NOISE: mn_q <= pwdata[CFG_W-1:0];
				default:               pn_q <= pn_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PROCESS_NOISE:     prdata = APB_DW'(pn_q);
			REG_MEASUREMENT_NOISE: prdata = APB_DW'(mn_q);
			default:               prdata = '0;
		endcase
	end

	assign cfg.process_noise     = pn_q;
	assign cfg.measurement_noise = mn_q;

endmodule

/* rtl/skf_div.sv */
// Radix-2 restoring divider producing the gain one quotient bit per cycle.
// Depends on skf_pkg.
module skf_div #(
	parameter int GAIN_FRAC_BITS = skf_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [skf_pkg::COV_W-1:0]   num,
	input  logic [skf_pkg::COV_W:0]     den,
	output logic                        done,
	output logic [GAIN_FRAC_BITS:0]     quot
);
	import skf_pkg::*;

	localparam int G   = GAIN_FRAC_BITS;
	localparam int DW  = COV_W + 1;
	localparam int CW  = $clog2(G + 1);

	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [G-1:0]  q_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic          zero_q;
	logic          one_q;
	logic [DW:0]   rem2;
	logic [DW:0]   diff;
	logic          fits;

	assign rem2 = {rem_q, 1'b0};
	assign diff = rem2 - {1'b0, den_q};
	assign fits = rem2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(G);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, num};
			den_q  <= den;
			q_q    <= '0;
			zero_q <= (den == '0);
			one_q  <= ({1'b0, num} >= den) && (den != '0);
		end else if (busy_q) begin
			rem_q <= fits ? diff[DW-1:0] : rem2[DW-1:0];
			q_q   <= {q_q[G-2:0], fits};
		end
	end

	assign done = done_q;

	always_comb begin
		if (zero_q) begin
			quot = '0;
		end else if (one_q) begin
			quot = {1'b1, {G{1'b0}}};
		end else begin
			quot = {1'b0, q_q};
		end
	end

endmodule

/* rtl/skf_mul.sv */
// Serial shift-add multiplier: signed multiplicand, unsigned multiplier,
// one multiplier bit per cycle. Depends on skf_pkg.
module skf_mul #(
	parameter int AW = skf_pkg::EST_W + 1,
	parameter int BW = skf_pkg::GAIN_FRAC_BITS_DEF + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [AW-1:0] a,
	input  logic [BW-1:0]        b,
	output logic                 done,
	output logic signed [AW:0]   prod_hi,
	output logic [BW-1:0]        prod_lo
);
	import skf_pkg::*;

	localparam int CW = $clog2(BW + 1);

	logic signed [AW-1:0] a_q;
	logic signed [AW:0]   hi_q;
	logic [BW-1:0]        lo_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic signed [AW:0]   sum;

	assign sum = lo_q[0] ? (hi_q + (AW+1)'(a_q)) : hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(BW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= sum >>> 1;
			lo_q <= {sum[0], lo_q[BW-1:1]};
		end
	end

	assign done    = done_q;
	assign prod_hi = hi_q;
	assign prod_lo = lo_q;

endmodule

/* rtl/scalar_kalman_filter.sv */
// Scalar Kalman filter: one measurement item in, one estimate and gain item out.
// An accepted item passes the prediction state, the bit-serial divider and then the two
// serial multipliers side by side before the result is registered.
// One item is in work at a time: a new item is accepted only once the last result has been
// loaded into the output register, which waits while a finished result is not yet taken.
// Reset clears estimate and covariance and loads the noise registers with defaults.
module scalar_kalman_filter #(
	parameter int SAMPLE_WIDTH   = skf_pkg::SAMPLE_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = skf_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	skf_sample_if.sink                 sample,
	skf_result_if.source               result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [skf_pkg::APB_AW-1:0] paddr,
	input  logic [skf_pkg::APB_DW-1:0] pwdata,
	output logic [skf_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import skf_pkg::*;

	localparam int G    = GAIN_FRAC_BITS;
	localparam int BW   = G + 1;
	localparam int DW   = EST_W + 1;
	localparam int WW   = SAMPLE_WIDTH + EST_FRAC + EST_W;
	localparam int SUMW = DW + 3;

	localparam logic signed [WW-1:0]   ZMAX = WW'(EST_MAX);
	localparam logic signed [WW-1:0]   ZMIN = WW'(EST_MIN);
	localparam logic signed [SUMW-1:0] SMAX = SUMW'(EST_MAX);
	localparam logic signed [SUMW-1:0] SMIN = SUMW'(EST_MIN);
	localparam logic [BW-1:0]          ONE  = {1'b1, {G{1'b0}}};

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_PRED = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_MUL  = 5'b01000,
		ST_WB   = 5'b10000
	} state_t;

	state_t state_q;
	cfg_t   cfg;

	logic signed [EST_W-1:0] est_q;
	logic [COV_W-1:0]        ecov_q;
	logic signed [EST_W-1:0] z_q;
	logic [COV_W-1:0]        cov_q;
	logic signed [DW-1:0]    diff_q;
	logic [BW-1:0]           gain_q;
	logic                    res_valid_q;
	logic signed [EST_W-1:0] res_est_q;
	logic [BW-1:0]           res_gain_q;

	logic                    accept;
	logic                    load_out;
	logic signed [WW-1:0]    z_wide;
	logic signed [EST_W-1:0] z_sat;
	logic [COV_W:0]          cov_sum;
	logic [COV_W-1:0]        cov_pred;
	logic [COV_W:0]          den;

	logic                    div_done;
	logic [BW-1:0]           quot;
	logic                    e_done;
	logic signed [DW:0]      e_hi;
	logic [BW-1:0]           e_lo;
	logic                    c_done;
	logic signed [COV_W+1:0] c_hi;
	logic [BW-1:0]           c_lo;

	logic signed [DW+1:0]    delta;
	logic signed [SUMW-1:0]  round_bit;
	logic signed [SUMW-1:0]  est_sum;
	logic signed [EST_W-1:0] est_new;
	logic [COV_W-1:0]        cov_new;

	skf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign sample.ready = (state_q == ST_IDLE);
	assign accept       = sample.valid && sample.ready;
	assign load_out     = (state_q == ST_WB) && (!res_valid_q || result.ready);

	assign z_wide = WW'(sample.measurement) <<< EST_FRAC;
	always_comb begin
		if (z_wide > ZMAX) begin
			z_sat = EST_W'(EST_MAX);
		end else if (z_wide < ZMIN) begin
			z_sat = EST_W'(EST_MIN);
		end else begin
			z_sat = z_wide[EST_W-1:0];
		end
	end

	assign cov_sum  = {1'b0, ecov_q} + {1'b0, cfg.process_noise};
	assign cov_pred = cov_sum[COV_W] ? {COV_W{1'b1}} : cov_sum[COV_W-1:0];
	assign den      = {1'b0, cov_q} + {1'b0, cfg.measurement_noise};

	skf_div #(.GAIN_FRAC_BITS(G)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_PRED),
		.num    (cov_q),
		.den    (den),
		.done   (div_done),
		.quot   (quot)
	);

	skf_mul #(.AW(DW), .BW(BW)) u_mul_est (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_done),
		.a       (diff_q),
		.b       (quot),
		.done    (e_done),
		.prod_hi (e_hi),
		.prod_lo (e_lo)
	);

	skf_mul #(.AW(COV_W + 1), .BW(BW)) u_mul_cov (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_done),
		.a       (signed'({1'b0, cov_q})),
		.b       (ONE - quot),
		.done    (c_done),
		.prod_hi (c_hi),
		.prod_lo (c_lo)
	);

	assign delta     = {e_hi, e_lo[BW-1]};
	assign round_bit = {{(SUMW-1){1'b0}}, e_lo[BW-2]};
	assign est_sum   = SUMW'(est_q) + SUMW'(delta) + round_bit;

	always_comb begin
		if (est_sum > SMAX) begin
			est_new = EST_W'(EST_MAX);
		end else if (est_sum < SMIN) begin
			est_new = EST_W'(EST_MIN);
		end else begin
			est_new = est_sum[EST_W-1:0];
		end
	end

	assign cov_new = {c_hi[COV_W-2:0], c_lo[BW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			est_q       <= '0;
			ecov_q      <= '0;
		end else begin
			if (load_out) begin
				res_valid_q <= 1'b1;
				est_q       <= est_new;
				ecov_q      <= cov_new;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_PRED;
				ST_PRED: state_q <= ST_DIV;
				ST_DIV:  if (div_done) state_q <= ST_MUL;
				ST_MUL:  if (e_done && c_done) state_q <= ST_WB;
				ST_WB:   if (load_out) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			z_q   <= z_sat;
			cov_q <= cov_pred;
		end
		if (state_q == ST_PRED) begin
			diff_q <= DW'(z_q) - DW'(est_q);
		end
		if (div_done) begin
			gain_q <= quot;
		end
		if (load_out) begin
			res_est_q  <= est_new;
			res_gain_q <= gain_q;
		end
	end

	assign result.valid             = res_valid_q;
	assign result.filtered_estimate = res_est_q;
	assign result.kalman_gain       = res_gain_q;

endmodule

/* tb/sv/scalar_kalman_filter_test.sv */
// Self-checking bench for scalar_kalman_filter: measurement items in, estimate and gain out.
// Relies on skf_pkg and the skf_sample_if / skf_result_if channels; nothing else.
// A local fixed-point filter predicts every result, and the noise registers are set over APB.
module scalar_kalman_filter_test;
	timeunit 1ns;
	timeprecision 1ps;

	import skf_pkg::*;

	localparam int SAMPLE_W       = SAMPLE_WIDTH_DEF;
	localparam int GAIN_FRAC      = GAIN_FRAC_BITS_DEF;
	localparam int RESULT_LATENCY = 2 * GAIN_FRAC + 5;
	localparam int LONG_HOLD      = 400;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_ITEMS    = 70;
	localparam longint unsigned GAIN_ONE = 64'd1 << GAIN_FRAC;
	localparam longint unsigned COV_MAX  = (64'd1 << COV_W) - 1;
	localparam logic [CFG_W-1:0] CFG_MAX = '1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic signed [EST_W-1:0] estimate;
		logic [GAIN_FRAC:0]      gain;
	} filter_out_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	skf_sample_if #(.SAMPLE_WIDTH(SAMPLE_W)) sample_ch ();
	skf_result_if #(.GAIN_FRAC_BITS(GAIN_FRAC)) result_ch ();

	scalar_kalman_filter #(
		.SAMPLE_WIDTH   (SAMPLE_W),
		.GAIN_FRAC_BITS (GAIN_FRAC)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	logic signed [EST_W-1:0] est_model;
	logic [COV_W-1:0]        cov_model;
	logic [CFG_W-1:0]        pn_model;
	logic [CFG_W-1:0]        mn_model;

	sample_t     pending_measurements[$];
	filter_out_t expected_outputs[$];
	int          queued_total;
	int          accepted_total;
	int          results_checked;
	int          mismatches;
	int          send_gap;
	int          recv_gap;
	int          hold_cycles;
	int          long_holds_done;
	bit          no_idle;
	bit          item_taken;

	function automatic longint clamp_q15_8(input longint v);
		if (v > EST_MAX) return EST_MAX;
		if (v < EST_MIN) return EST_MIN;
		return v;
	endfunction

	function automatic filter_out_t kalman_step(input sample_t meas);
		longint          z;
		longint          diff;
		longint          delta;
		longint unsigned cov_pred;
		longint unsigned den;
		longint unsigned gain;
		filter_out_t     out;
		z = clamp_q15_8(longint'(meas) * (64'sd1 << EST_FRAC));
		cov_pred = longint'(cov_model) + longint'(pn_model);
		if (cov_pred > COV_MAX) cov_pred = COV_MAX;
		den = cov_pred + longint'(mn_model);
		gain = 0;
		if (den != 0) begin
			gain = (cov_pred << GAIN_FRAC) / den;
			if (gain > GAIN_ONE) gain = GAIN_ONE;
		end
		diff = z - longint'(est_model);
		delta = (longint'(gain) * diff + (64'sd1 <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC;
		est_model = EST_W'(clamp_q15_8(longint'(est_model) + delta));
		cov_model = COV_W'((cov_pred * (GAIN_ONE - gain)) >> GAIN_FRAC);
		out.estimate = est_model;
		out.gain     = (GAIN_FRAC + 1)'(gain);
		return out;
	endfunction

	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	always @(posedge clk) begin
		filter_out_t want;
		item_taken <= arst_n && sample_ch.valid && sample_ch.ready;
		if (arst_n) begin
			if (sample_ch.valid && sample_ch.ready) begin
				expected_outputs.push_back(kalman_step(sample_ch.measurement));
				accepted_total++;
			end
			if (result_ch.valid && result_ch.ready) begin
				results_checked++;
				if (expected_outputs.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result estimate %0d gain %0d", $time,
						result_ch.filtered_estimate, result_ch.kalman_gain);
				end else begin
					want = expected_outputs.pop_front();
					if (result_ch.filtered_estimate !== want.estimate) begin
						mismatches++;
						$display("%0t: filtered_estimate expected %0d actual %0d", $time,
							want.estimate, result_ch.filtered_estimate);
					end
					if (result_ch.kalman_gain !== want.gain) begin
						mismatches++;
						$display("%0t: kalman_gain expected %0d actual %0d", $time,
							want.gain, result_ch.kalman_gain);
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		logic    next_valid;
		sample_t next_meas;
		if (arst_n) begin
			next_valid = sample_ch.valid;
			next_meas  = sample_ch.measurement;
			if (!sample_ch.valid || item_taken) begin
				next_valid = 1'b0;
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_measurements.size() != 0) begin
					next_valid = 1'b1;
					next_meas  = pending_measurements.pop_front();
					send_gap   = no_idle ? 0 : idle_length();
				end
			end
			sample_ch.valid       <= next_valid;
			sample_ch.measurement <= next_meas;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_cycles > 0) begin
				hold_cycles--;
				result_ch.ready <= 1'b0;
			end else if (long_holds_done < 2 && results_checked >= 80 + 250 * long_holds_done
					&& pending_measurements.size() > 10) begin
				hold_cycles = LONG_HOLD;
				long_holds_done++;
				result_ch.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				recv_gap = no_idle ? 0 : idle_length();
			end
		end
	end

	task automatic queue_sample(input sample_t meas);
		pending_measurements.push_back(meas);
		queued_total++;
	endtask

	task automatic queue_sensor_run(input int count);
		int target;
		int value;
		target = $urandom_range(0, 65535) - 32768;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: value = $urandom_range(0, 65535) - 32768;
				3: begin
					target = $urandom_range(0, 65535) - 32768;
					value = target;
				end
				default: value = target + $urandom_range(0, 512) - 256;
			endcase
			if (value > 32767) value = 32767;
			if (value < -32768) value = -32768;
			queue_sample(SAMPLE_W'(value));
		end
	endtask

	task automatic wait_for_drain();
		while (accepted_total != queued_total || expected_outputs.size() != 0)
			@(negedge clk);
		repeat (RESULT_LATENCY + 8) @(negedge clk);
	endtask

	task automatic write_register(input reg_idx_t idx, input logic [CFG_W-1:0] value);
		logic [APB_DW-1:0] data;
		data = {8'($urandom), value};
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		case (idx)
			REG_PROCESS_NOISE:     pn_model = value;
			REG_MEASUREMENT_NOISE: mn_model = value;
			default: ;
		endcase
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[CFG_W-1:0] !== value) begin
			mismatches++;
			$display("%0t: register %0d read expected %0d actual %0d", $time, idx, value,
				prdata[CFG_W-1:0]);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_noise(input logic [CFG_W-1:0] pn, input logic [CFG_W-1:0] mn);
		wait_for_drain();
		write_register(REG_PROCESS_NOISE, pn);
		write_register(REG_MEASUREMENT_NOISE, mn);
	endtask

	function automatic logic [CFG_W-1:0] random_noise();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return CFG_MAX;
			2, 3: return CFG_W'($urandom_range(0, 4096));
			4: return CFG_W'($urandom_range(4096, 1 << 20));
			default: return CFG_W'($urandom);
		endcase
	endfunction

	initial begin
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		sample_ch.valid       = 1'b0;
		sample_ch.measurement = '0;
		result_ch.ready       = 1'b0;
		est_model = '0;
		cov_model = '0;
		pn_model  = PN_RESET;
		mn_model  = MN_RESET;
		arst_n = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		no_idle = 1'b0;
		queue_sample(16'sd0);
		queue_sample(16'sd32767);
		queue_sample(-16'sd32768);
		queue_sample(16'sd32767);
		queue_sample(-16'sd1);
		queue_sample(16'sd1);
		queue_sample(16'sh5555);
		queue_sample(16'shAAAA);

		// With both noises at zero the first item drives the covariance to zero,
		// after which the denominator is zero and the gain stays at zero.
		set_noise('0, '0);
		queue_sample(-16'sd32768);
		queue_sample(16'sd32767);
		queue_sample(16'sd100);
		queue_sample(-16'sd7);

		set_noise(CFG_MAX, '0);
		queue_sample(16'sd32767);
		queue_sample(-16'sd32768);
		queue_sample(16'sd12);

		set_noise(CFG_MAX, CFG_MAX);
		queue_sample(-16'sd32768);
		queue_sample(16'sd32767);
		queue_sample(16'sd0);
		queue_sample(-16'sd1);

		set_noise('0, CFG_MAX);
		queue_sample(16'sd32767);
		queue_sample(-16'sd32768);
		queue_sample(16'sd32767);
		queue_sample(16'sd4);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			set_noise(random_noise(), random_noise());
			no_idle = (p % 3 == 1);
			queue_sensor_run(PHASE_ITEMS);
		end

		wait_for_drain();
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
